[design/wpg_pkg.sv]
// Package for the wrapped phase gradient unit.
// Holds field types, register indexes, size limits and the scan flag struct.
// No dependencies.
package wpg_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PHASE_BITS_DEF = 16;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MIN_SIZE       = 3;
  localparam int ROW_W          = 12;
  localparam int SIZE_W         = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int HALF_PI_Q12    = 6434;
  localparam int WIDE_W         = 33;

  localparam logic              DIR_RESET  = 1'b0;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd1024;

  typedef logic signed [14:0] phase_in_t;
  typedef logic signed [15:0] grad_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRINGE_DIR   = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic row_mode;
    logic has_first;
    logic has_diff;
    logic has_second;
    logic last_second;
  } scan_flags_t;

endpackage

[design/wpg_in_if.sv]
// Input channel of the wrapped phase gradient unit: one pixel per beat.
// Depends on wpg_pkg.
interface wpg_in_if import wpg_pkg::*; ();
  logic      valid;
  logic      ready;
  phase_in_t phase_main;
  phase_in_t phase_alt;

  modport source(output valid, output phase_main, output phase_alt, input ready);
  modport sink(input valid, input phase_main, input phase_alt, output ready);
endinterface

[design/wpg_out_if.sv]
// Result channel of the wrapped phase gradient unit: one gradient per beat.
// Depends on wpg_pkg.
interface wpg_out_if import wpg_pkg::*; ();
  logic  valid;
  logic  ready;
  grad_t gradient_value;
  logic  frame_last;

  modport source(output valid, output gradient_value, output frame_last, input ready);
  modport sink(input valid, input gradient_value, input frame_last, output ready);
endinterface

[design/wpg_scan_ctrl.sv]
// Configuration registers, size saturation and raster position counters.
// Produces the per-pixel result flags and the line buffer column. Depends on wpg_pkg.
module wpg_scan_ctrl import wpg_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  cfg_data_t                    cfg_wdata,
  input  logic                         advance,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output scan_flags_t                  flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;

  logic              dir_r;
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [CW-1:0]     col_r;
  logic [ROW_W-1:0]  row_r;

  logic [WW-1:0]     wide_w;
  logic [WW-1:0]     eff_w;
  logic [SIZE_W-1:0] eff_h;
  logic              last_col;
  logic              last_row;
  logic              col_ge1;
  logic              col_ge2;
  logic              row_ge1;
  logic              row_ge2;

  always_comb begin
    wide_w = WW'(width_r);
    priority if (wide_w < WW'(MIN_SIZE)) begin
      eff_w = WW'(MIN_SIZE);
    end else if (wide_w > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = wide_w;
    end
    priority if (height_r < SIZE_W'(MIN_SIZE)) begin
      eff_h = SIZE_W'(MIN_SIZE);
    end else if (height_r > SIZE_W'(MAX_HEIGHT)) begin
      eff_h = SIZE_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  assign last_col = (WW'(col_r) + WW'(1)) >= eff_w;
  assign last_row = (SIZE_W'(row_r) + SIZE_W'(1)) >= eff_h;
  assign col_ge1  = col_r != '0;
  assign col_ge2  = col_r > CW'(1);
  assign row_ge1  = row_r != '0;
  assign row_ge2  = row_r > ROW_W'(1);

  always_comb begin
    flags.row_mode = dir_r;
    if (dir_r) begin
      flags.has_first   = row_ge1;
      flags.has_diff    = row_ge2;
      flags.has_second  = row_ge1 && last_row;
      flags.last_second = last_col;
    end else begin
      flags.has_first   = col_ge1;
      flags.has_diff    = col_ge2;
      flags.has_second  = last_col;
      flags.last_second = last_row;
    end
  end

  assign col = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= DIR_RESET;
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRINGE_DIR: begin
          dir_r <= cfg_wdata[0];
          col_r <= '0;
          row_r <= '0;
        end
        REG_IMAGE_WIDTH: begin
          width_r <= cfg_wdata;
          col_r   <= '0;
          row_r   <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_r <= cfg_wdata;
          col_r    <= '0;
          row_r    <= '0;
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < eff_w)
    else $error("column counter beyond line width");

  a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last_col && !cfg_we |=> col_r == '0)
    else $error("column counter did not wrap at end of line");

endmodule

[design/wpg_line_buf.sv]
// Two-line phase store for the main and alternative maps, one memory row per column.
// Each row holds newer and older line; a write shifts newer into older. Depends on wpg_pkg.
module wpg_line_buf import wpg_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
  input  logic signed [PHASE_BITS-1:0]  wr_main,
  input  logic signed [PHASE_BITS-1:0]  wr_alt,
  output logic signed [PHASE_BITS-1:0]  rd_main_new,
  output logic signed [PHASE_BITS-1:0]  rd_main_old,
  output logic signed [PHASE_BITS-1:0]  rd_alt_new,
  output logic signed [PHASE_BITS-1:0]  rd_alt_old
);

  localparam int EW = 4 * PHASE_BITS;

  logic [EW-1:0] mem [MAX_WIDTH];
  logic [EW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_main, rd_main_new, wr_alt, rd_alt_new};
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign rd_main_new = rd_r[EW-1 -: PHASE_BITS];
  assign rd_main_old = rd_r[EW-PHASE_BITS-1 -: PHASE_BITS];
  assign rd_alt_new  = rd_r[2*PHASE_BITS-1 -: PHASE_BITS];
  assign rd_alt_old  = rd_r[PHASE_BITS-1:0];

endmodule

[design/wpg_result_q.sv]
// Result register with one extra slot for the trailing border result of a pixel.
// Drives the result channel. Depends on wpg_pkg and wpg_out_if.
module wpg_result_q import wpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  scan_flags_t flags,
  input  grad_t       grad,
  output logic        free,
  wpg_out_if.source   out_chan
);

  logic [1:0] cnt_r;
  grad_t      grad_r;
  logic       last_r;
  logic       tail_last_r;
  logic       out_beat;

  assign out_chan.valid          = cnt_r != 2'd0;
  assign out_chan.gradient_value = grad_r;
  assign out_chan.frame_last     = last_r;
  assign out_beat                = out_chan.valid && out_chan.ready;
  assign free                    = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= {1'b0, flags.has_first} + {1'b0, flags.has_second};
    end else if (out_beat) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grad_r      <= flags.has_first ? grad : '0;
      last_r      <= flags.has_first ? 1'b0 : flags.last_second;
      tail_last_r <= flags.last_second;
    end else if (out_beat && cnt_r == 2'd2) begin
      grad_r <= '0;
      last_r <= tail_last_r;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result register overwritten");

  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && out_beat |=> cnt_r == 2'd1 && grad_r == '0)
    else $error("trailing border result not zero");

endmodule

[design/wrapped_phase_gradient_unit.sv]
// Wrapped phase gradient unit: central difference of a wrapped phase raster.
// A result passes the pixel register, then the result register, before it is offered.
// Throughput: one pixel per cycle while results are taken; a pixel with two results stalls input.
// Reset: synchronous, clears counters and result state, loads register defaults.
// The line memory is not cleared; every frame writes a line before reading it.
module wrapped_phase_gradient_unit import wpg_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  wpg_in_if.sink               in_chan,
  wpg_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  cfg_data_t            cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic signed [WIDE_W-1:0] HALF_PI_W = WIDE_W'(HALF_PI_Q12);

  logic        in_beat;
  logic [CW-1:0] scan_col;
  scan_flags_t scan_flags;
  logic        q_free;
  logic        s1_move;

  logic                         s1_valid_r;
  scan_flags_t                  s1_flags_r;
  logic [CW-1:0]                s1_col_r;
  logic signed [PHASE_BITS-1:0] s1_main_r;
  logic signed [PHASE_BITS-1:0] s1_alt_r;
  logic signed [PHASE_BITS-1:0] hist_main0_r;
  logic signed [PHASE_BITS-1:0] hist_main1_r;
  logic signed [PHASE_BITS-1:0] hist_alt0_r;
  logic signed [PHASE_BITS-1:0] hist_alt1_r;

  logic signed [WIDE_W-1:0]     in_main_w;
  logic signed [WIDE_W-1:0]     in_alt_w;
  logic signed [PHASE_BITS-1:0] rd_main_new;
  logic signed [PHASE_BITS-1:0] rd_main_old;
  logic signed [PHASE_BITS-1:0] rd_alt_new;
  logic signed [PHASE_BITS-1:0] rd_alt_old;

  logic signed [WIDE_W-1:0] center_w;
  logic signed [WIDE_W-1:0] prev_main_w;
  logic signed [WIDE_W-1:0] prev_alt_w;
  logic signed [WIDE_W-1:0] diff_w;
  logic                     center_inside;
  grad_t                    grad;

  assign in_beat       = in_chan.valid && in_chan.ready;
  assign s1_move       = s1_valid_r && q_free;
  assign in_chan.ready = !s1_valid_r || q_free;
  assign in_main_w     = WIDE_W'(in_chan.phase_main);
  assign in_alt_w      = WIDE_W'(in_chan.phase_alt);

  wpg_scan_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (in_beat),
    .col       (scan_col),
    .flags     (scan_flags)
  );

  wpg_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PHASE_BITS (PHASE_BITS)
  ) u_line (
    .clk         (clk),
    .rd_en       (in_beat),
    .rd_addr     (scan_col),
    .wr_en       (s1_move),
    .wr_addr     (s1_col_r),
    .wr_main     (s1_main_r),
    .wr_alt      (s1_alt_r),
    .rd_main_new (rd_main_new),
    .rd_main_old (rd_main_old),
    .rd_alt_new  (rd_alt_new),
    .rd_alt_old  (rd_alt_old)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_beat) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_flags_r <= scan_flags;
      s1_col_r   <= scan_col;
      s1_main_r  <= in_main_w[PHASE_BITS-1:0];
      s1_alt_r   <= in_alt_w[PHASE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_main0_r <= '0;
      hist_main1_r <= '0;
      hist_alt0_r  <= '0;
      hist_alt1_r  <= '0;
    end else if (s1_move) begin
      hist_main0_r <= s1_main_r;
      hist_main1_r <= hist_main0_r;
      hist_alt0_r  <= s1_alt_r;
      hist_alt1_r  <= hist_alt0_r;
    end
  end

  always_comb begin
    if (s1_flags_r.row_mode) begin
      center_w    = WIDE_W'(rd_main_new);
      prev_main_w = WIDE_W'(rd_main_old);
      prev_alt_w  = WIDE_W'(rd_alt_old);
    end else begin
      center_w    = WIDE_W'(hist_main0_r);
      prev_main_w = WIDE_W'(hist_main1_r);
      prev_alt_w  = WIDE_W'(hist_alt1_r);
    end
    center_inside = (center_w > -HALF_PI_W) && (center_w < HALF_PI_W);
    if (center_inside) begin
      diff_w = prev_main_w - WIDE_W'(s1_main_r);
    end else begin
      diff_w = prev_alt_w - WIDE_W'(s1_alt_r);
    end
    grad = s1_flags_r.has_diff ? diff_w[15:0] : '0;
  end

  wpg_result_q u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s1_move),
    .flags    (s1_flags_r),
    .grad     (grad),
    .free     (q_free),
    .out_chan (out_chan)
  );

  a_beat_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> s1_valid_r)
    else $error("accepted pixel lost before pixel register");

endmodule

[verif/wrapped_phase_gradient_unit_tb.sv]
// Testbench for wrapped_phase_gradient_unit: raster pixels in, gradient beats out.
// A behavioral gradient predictor feeds a queue that every result beat is checked against.
// Depends on wpg_pkg, wpg_in_if, wpg_out_if and the unit itself.
`timescale 1ns / 100ps

module wrapped_phase_gradient_unit_tb import wpg_pkg::*; ();

  localparam int IDLE_PCT    = 34;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 4;
  localparam int RANDOM_ITEMS = 1800;

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;
  typedef logic signed [PHASE_BITS_DEF-1:0] stored_phase_t;

  localparam reg_idx_t REG_UNUSED = reg_idx_t'(3);

  typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    reg_idx_t  idx;
    phase_in_t pm;
    phase_in_t pa;
    cfg_data_t val;
    logic      typed;
    grad_t     grad;
  } stim_row_t;

  typedef struct packed {
    grad_t grad;
    logic  last;
  } grad_beat_t;

  localparam stim_row_t DIRECTED [30] = '{
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd12868, 15'sd0, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd0, -15'sd12868, 13'd0, 1'b1, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, -15'sd12868, 15'sd5, 13'd0, 1'b1, 16'sd25736},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd12868, 15'sd12868, 13'd0, 1'b1, -16'sd25736},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd6434, 15'sd100, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, -15'sd6434, -15'sd100, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd6433, -15'sd12868, 13'd0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_UNUSED, 15'sd0, 15'sd0, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, -15'sd6433, 15'sd12868, 13'd0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_IMAGE_WIDTH, 15'sd0, 15'sd0, 13'd0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 15'sd0, 15'sd0, 13'd2, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd1000, -15'sd3000, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, -15'sd1000, 15'sd3000, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd7000, -15'sd7000, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, -15'sd7000, 15'sd7000, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd6434, 15'sd12868, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd0, -15'sd12868, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd12868, 15'sd1, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, -15'sd12868, -15'sd1, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd3, 15'sd4000, 13'd0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_FRINGE_DIR, 15'sd0, 15'sd0, 13'd1, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, -15'sd12868, 15'sd12868, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd6433, -15'sd6434, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, -15'sd6433, 15'sd6434, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd100, -15'sd200, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, -15'sd6434, 15'sd300, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd6434, -15'sd400, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd12868, -15'sd12868, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, -15'sd1, 15'sd2, 13'd0, 1'b0, 16'sd0},
    '{ROW_PIXEL, REG_FRINGE_DIR, 15'sd0, 15'sd0, 13'd0, 1'b0, 16'sd0}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  reg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  wpg_in_if  in_if ();
  wpg_out_if out_if ();

  wrapped_phase_gradient_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  logic          cfg_dir = DIR_RESET;
  cfg_data_t     cfg_width = SIZE_RESET;
  cfg_data_t     cfg_height = SIZE_RESET;
  stored_phase_t line_main_old [MAX_WIDTH_DEF];
  stored_phase_t line_main_new [MAX_WIDTH_DEF];
  stored_phase_t line_alt_old [MAX_WIDTH_DEF];
  stored_phase_t line_alt_new [MAX_WIDTH_DEF];
  stored_phase_t hist_main [2] = '{16'sd0, 16'sd0};
  stored_phase_t hist_alt [2] = '{16'sd0, 16'sd0};
  int            cur_row = 0;
  int            cur_col = 0;

  grad_beat_t expected_grads [$];
  grad_beat_t head_grad;
  int         mismatch_count = 0;
  logic       steady = 1'b0;
  int         hold_requests = 0;
  int         holds_served = 0;
  int         idle_cycles = 0;

  function automatic int clamp_size(input int v, input int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic in_band(input stored_phase_t p);
    return (p > -HALF_PI_Q12) && (p < HALF_PI_Q12);
  endfunction

  function automatic phase_in_t rand_phase();
    int v;
    case ($urandom_range(5))
      0: v = HALF_PI_Q12 - 2 + int'($urandom_range(4));
      1: v = -HALF_PI_Q12 - 2 + int'($urandom_range(4));
      2: v = ($urandom_range(1) != 0) ? 12868 : -12868;
      default: v = int'($urandom_range(25736)) - 12868;
    endcase
    return phase_in_t'(v);
  endfunction

  function automatic cfg_data_t pick_size();
    case ($urandom_range(19))
      0: return cfg_data_t'($urandom_range(2));
      1: return cfg_data_t'($urandom_range(8191, 4097));
      2: return cfg_data_t'(MAX_WIDTH_DEF);
      default: return cfg_data_t'($urandom_range(10, 3));
    endcase
  endfunction

  task automatic apply_reg(input reg_idx_t idx, input cfg_data_t val);
    logic known;
    known = 1'b1;
    case (idx)
      REG_FRINGE_DIR:   cfg_dir = val[0];
      REG_IMAGE_WIDTH:  cfg_width = val;
      REG_IMAGE_HEIGHT: cfg_height = val;
      default:          known = 1'b0;
    endcase
    if (known) begin
      cur_row = 0;
      cur_col = 0;
    end
  endtask

  task automatic next_gradients(input phase_in_t pm_in, input phase_in_t pa_in,
                                input logic typed, input grad_t typed_grad);
    stored_phase_t pm;
    stored_phase_t pa;
    int            w;
    int            h;
    logic          last_col;
    logic          last_row;
    grad_t         g;
    grad_beat_t    beats [2];
    int            n;
    pm = pm_in;
    pa = pa_in;
    w = clamp_size(int'(cfg_width), MAX_WIDTH_DEF);
    h = clamp_size(int'(cfg_height), MAX_HEIGHT);
    last_col = (cur_col + 1 >= w);
    last_row = (cur_row + 1 >= h);
    n = 0;
    g = '0;
    if (cfg_dir) begin
      if (cur_row >= 1) begin
        if (cur_row >= 2) begin
          g = in_band(line_main_new[cur_col]) ? line_main_old[cur_col] - pm
                                              : line_alt_old[cur_col] - pa;
        end
        beats[n] = '{g, 1'b0};
        n++;
        if (last_row) begin
          beats[n] = '{16'sd0, last_col};
          n++;
        end
      end
    end else begin
      if (cur_col >= 1) begin
        if (cur_col >= 2) begin
          g = in_band(hist_main[0]) ? hist_main[1] - pm : hist_alt[1] - pa;
        end
        beats[n] = '{g, 1'b0};
        n++;
      end
      if (last_col) begin
        beats[n] = '{16'sd0, last_row};
        n++;
      end
    end
    if (typed && n > 0) beats[0].grad = typed_grad;
    for (int k = 0; k < n; k++) expected_grads.push_back(beats[k]);

    line_main_old[cur_col] = line_main_new[cur_col];
    line_main_new[cur_col] = pm;
    line_alt_old[cur_col] = line_alt_new[cur_col];
    line_alt_new[cur_col] = pa;
    hist_main[1] = hist_main[0];
    hist_main[0] = pm;
    hist_alt[1] = hist_alt[0];
    hist_alt[0] = pa;
    if (last_col) begin
      cur_col = 0;
      cur_row = last_row ? 0 : cur_row + 1;
    end else begin
      cur_col = cur_col + 1;
    end
  endtask

  task automatic send_pixel(input phase_in_t pm, input phase_in_t pa,
                            input logic typed, input grad_t typed_grad);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.phase_main <= pm;
    in_if.phase_alt  <= pa;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    next_gradients(pm, pa, typed, typed_grad);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_grads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input cfg_data_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_grads.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual gradient %0d frame_last %0b",
                 $time, out_if.gradient_value, out_if.frame_last);
        mismatch_count++;
      end else begin
        head_grad = expected_grads.pop_front();
        if (out_if.gradient_value !== head_grad.grad) begin
          $display("%0t: gradient_value expected %0d actual %0d",
                   $time, head_grad.grad, out_if.gradient_value);
          mismatch_count++;
        end
        if (out_if.frame_last !== head_grad.last) begin
          $display("%0t: frame_last expected %0b actual %0b",
                   $time, head_grad.last, out_if.frame_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("wrapped_phase_gradient_unit test failed");
    $finish;
  end

  initial begin
    int       phase_no;
    int       sent_random;
    int       frame_px;
    int       n_items;
    reg_idx_t reg_sel;
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.phase_main <= '0;
    in_if.phase_alt  <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_FRINGE_DIR;
    cfg_wdata        <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIRECTED[i].idx, DIRECTED[i].val);
      end else begin
        send_pixel(DIRECTED[i].pm, DIRECTED[i].pa, DIRECTED[i].typed, DIRECTED[i].grad);
      end
    end

    sent_random = 0;
    for (phase_no = 0; sent_random < RANDOM_ITEMS; phase_no++) begin
      wait_idle();
      steady = (phase_no >= 6 && phase_no < 12);
      if ($urandom_range(3) == 0) begin
        reg_sel = reg_idx_t'($urandom_range(3));
        case (reg_sel)
          REG_FRINGE_DIR:   write_reg(reg_sel, cfg_data_t'($urandom_range(1)));
          REG_IMAGE_WIDTH,
          REG_IMAGE_HEIGHT: write_reg(reg_sel, pick_size());
          default:          write_reg(reg_sel, cfg_data_t'($urandom_range(8191)));
        endcase
      end else begin
        write_reg(REG_FRINGE_DIR, cfg_data_t'($urandom_range(1)));
        write_reg(REG_IMAGE_WIDTH, pick_size());
        write_reg(REG_IMAGE_HEIGHT, pick_size());
      end
      frame_px = clamp_size(int'(cfg_width), MAX_WIDTH_DEF) *
                 clamp_size(int'(cfg_height), MAX_HEIGHT);
      if (frame_px <= 120 && $urandom_range(4) != 0) begin
        n_items = frame_px * int'($urandom_range(2, 1));
      end else begin
        n_items = int'($urandom_range(40, 1));
      end
      if (phase_no == 3) begin
        hold_requests++;
        if (n_items < 100) n_items = 100;
      end
      repeat (n_items) begin
        send_pixel(rand_phase(), rand_phase(), 1'b0, '0);
        sent_random++;
      end
    end
    steady = 1'b0;

    wait_idle();
    if (mismatch_count == 0) begin
      $display("wrapped_phase_gradient_unit test passed");
    end else begin
      $display("wrapped_phase_gradient_unit test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/wpg_pkg.sv
design/wpg_in_if.sv
design/wpg_out_if.sv
design/wpg_scan_ctrl.sv
design/wpg_line_buf.sv
design/wpg_result_q.sv
design/wrapped_phase_gradient_unit.sv
verif/wrapped_phase_gradient_unit_tb.sv
